// ===== src/s256_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package s256_pkg;

  // Source of the byte that is shifted into the block window.
  typedef enum logic [2:0] {
    PUSH_NONE,
    PUSH_MSG,
    PUSH_MARK,
    PUSH_ZERO,
    PUSH_LEN
  } push_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    push_sel_e   push_sel;
    logic        load_vars;
    logic        round_en;
    logic [5:0]  rnd;
    logic        fold;
    logic        clear;
    logic [2:0]  word_idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_last;
    logic fill_pre_len;
  } sts_t;

  localparam logic [7:0] PAD_MARK = 8'h80;
  // Fill level after which the next byte lands at offset 56, the start of the length field.
  localparam logic [5:0] LEN_FILL_M1 = 6'd55;
  localparam logic [5:0] LAST_SLOT = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Sigma functions of the round and of the message schedule.
  function automatic logic [31:0] big_s0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_s1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_s0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_s1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== src/s256_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s256_dpath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  s256_pkg::cmd_t cmd_i,
  input  logic [7:0]     msg_byte_i,
  output s256_pkg::sts_t sts_o,
  output logic [31:0]    digest_word_o
);
  import s256_pkg::*;

  logic [511:0] w_q, w_d;
  logic [5:0]   fill_q, fill_d;
  logic [60:0]  cnt_q, cnt_d;
  logic [63:0]  len_q, len_d;
  logic [31:0]  h_q [8];
  logic [31:0]  h_d [8];
  logic [31:0]  v_q [8];
  logic [31:0]  v_d [8];
  logic [7:0]   push_byte;
  logic         push_en;
  logic [31:0]  w_new, t1, t2;

  // Byte source for the block window.
  always_comb begin
    case (cmd_i.push_sel)
      PUSH_MSG:  push_byte = msg_byte_i;
      PUSH_MARK: push_byte = PAD_MARK;
      PUSH_LEN:  push_byte = len_q[63:56];
      default:   push_byte = 8'h00;
    endcase
  end

  assign push_en = (cmd_i.push_sel != PUSH_NONE);

  // Next schedule word from window words 0, 1, 9 and 14.
  assign w_new = small_s1(w_q[511-32*14 -: 32]) + w_q[511-32*9 -: 32]
               + small_s0(w_q[511-32*1 -: 32]) + w_q[511:480];

  // Round function on the working variables.
  assign t1 = v_q[7] + big_s1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + ROUND_K[cmd_i.rnd] + w_q[511:480];
  assign t2 = big_s0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // Block window: bytes shift in at the bottom, schedule words shift during rounds.
  always_comb begin
    w_d    = w_q;
    fill_d = fill_q;
    if (push_en) begin
      w_d    = {w_q[503:0], push_byte};
      fill_d = fill_q + 6'd1;
    end else if (cmd_i.round_en) begin
      w_d = {w_q[479:0], w_new};
    end
  end

  // Message byte count and the length field shifted out at the end.
  always_comb begin
    cnt_d = cnt_q;
    len_d = len_q;
    if (cmd_i.push_sel == PUSH_MSG) begin
      cnt_d = cnt_q + 61'd1;
    end
    if (cmd_i.push_sel == PUSH_MARK) begin
      len_d = {cnt_q, 3'b000};
    end else if (cmd_i.push_sel == PUSH_LEN) begin
      len_d = {len_q[55:0], 8'h00};
    end
    if (cmd_i.clear) begin
      cnt_d = '0;
    end
  end

  // Working variables and chaining words.
  always_comb begin
    v_d = v_q;
    h_d = h_q;
    if (cmd_i.load_vars) begin
      v_d = h_q;
    end else if (cmd_i.round_en) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
    if (cmd_i.fold) begin
      for (int i = 0; i < 8; i++) begin
        h_d[i] = h_q[i] + v_q[i];
      end
    end else if (cmd_i.clear) begin
      h_d = H_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
      h_q    <= H_INIT;
    end else begin
      fill_q <= fill_d;
      cnt_q  <= cnt_d;
      h_q    <= h_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    len_q <= len_d;
    v_q   <= v_d;
  end

  assign sts_o.fill_last    = (fill_q == LAST_SLOT);
  assign sts_o.fill_pre_len = (fill_q == LEN_FILL_M1);
  assign digest_word_o      = h_q[cmd_i.word_idx];

endmodule

`default_nettype wire

// ===== src/s256_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s256_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           has_byte_i,
  input  logic           is_last_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [2:0]     word_index_o,
  output logic           is_last_word_o,
  input  s256_pkg::sts_t sts_i,
  output s256_pkg::cmd_t cmd_o
);
  import s256_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD_MARK,
    S_PAD_ZERO,
    S_PAD_LEN,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_EMIT
  } state_e;

  state_e     state_q, state_d, ret_q, ret_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;

  // Sequencing: bytes, padding, compression and digest output.
  always_comb begin
    state_d        = state_q;
    ret_d          = ret_q;
    rnd_d          = rnd_q;
    idx_d          = idx_q;
    cmd_o.push_sel  = PUSH_NONE;
    cmd_o.load_vars = 1'b0;
    cmd_o.round_en  = 1'b0;
    cmd_o.rnd       = rnd_q;
    cmd_o.fold      = 1'b0;
    cmd_o.clear     = 1'b0;
    cmd_o.word_idx  = idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (has_byte_i) begin
            cmd_o.push_sel = PUSH_MSG;
          end
          if (has_byte_i && sts_i.fill_last) begin
            state_d = S_LOAD;
            ret_d   = is_last_i ? S_PAD_MARK : S_IDLE;
          end else if (is_last_i) begin
            state_d = S_PAD_MARK;
          end
        end
      end
      S_PAD_MARK: begin
        cmd_o.push_sel = PUSH_MARK;
        if (sts_i.fill_last) begin
          state_d = S_LOAD;
          ret_d   = S_PAD_ZERO;
        end else if (sts_i.fill_pre_len) begin
          state_d = S_PAD_LEN;
        end else begin
          state_d = S_PAD_ZERO;
        end
      end
      S_PAD_ZERO: begin
        cmd_o.push_sel = PUSH_ZERO;
        if (sts_i.fill_last) begin
          state_d = S_LOAD;
          ret_d   = S_PAD_ZERO;
        end else if (sts_i.fill_pre_len) begin
          state_d = S_PAD_LEN;
        end
      end
      S_PAD_LEN: begin
        cmd_o.push_sel = PUSH_LEN;
        if (sts_i.fill_last) begin
          state_d = S_LOAD;
          ret_d   = S_EMIT;
        end
      end
      S_LOAD: begin
        cmd_o.load_vars = 1'b1;
        rnd_d           = '0;
        state_d         = S_ROUND;
      end
      S_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        cmd_o.fold = 1'b1;
        state_d    = ret_q;
      end
      S_EMIT: begin
        if (out_ready_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == LAST_WORD) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_EMIT);
  assign word_index_o   = idx_q;
  assign is_last_word_o = (idx_q == LAST_WORD);

endmodule

`default_nettype wire

// ===== src/sha256_stream_hasher_unit.sv =====
// Items are taken while the block is idle; an item that completes a 64-byte block
// starts a compression (variable load, 64 rounds at one per cycle, chaining fold),
// during which no item is taken. A final item then shifts in the padding and length
// bytes, runs one or two more compressions and offers eight digest words, one per word taken.
// Reset (rst_ni low, asynchronous) loads the initial hash words, clears fill and
// byte count, and leaves the block ready for the first item.
`timescale 1ns / 1ps
`default_nettype none

module sha256_stream_hasher_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        is_last_word_o
);
  import s256_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Controller: item handshake, padding sequence, rounds and output.
  s256_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .has_byte_i     (has_byte_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .word_index_o   (word_index_o),
    .is_last_word_o (is_last_word_o),
    .sts_i          (sts),
    .cmd_o          (cmd)
  );

  // Datapath: block window, schedule, round logic and chaining words.
  s256_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .msg_byte_i    (msg_byte_i),
    .sts_o         (sts),
    .digest_word_o (digest_word_o)
  );

endmodule

`default_nettype wire

// ===== src/s256_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module s256_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  word_index_o,
  input logic        is_last_word_o
);

  // No item is taken while a digest is being delivered.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_o && in_ready_o))
    else $error("input ready while digest output is valid");

  // A digest always starts at its most significant word.
  a_first_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (word_index_o == 3'd0))
    else $error("digest did not start at word 0");

  // Words follow one another without gaps.
  a_word_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !is_last_word_o) |=>
      (out_valid_o && (word_index_o == $past(word_index_o) + 3'd1)))
    else $error("digest word sequence broken");

  // The last-word flag marks exactly the eighth word.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_last_word_o == (word_index_o == 3'd7)))
    else $error("last-word flag does not match word index");

  // After the eighth word the block is ready for a new message.
  a_ready_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && is_last_word_o) |=> (in_ready_o && !out_valid_o))
    else $error("block not ready after digest");

endmodule

bind sha256_stream_hasher_unit s256_checker u_s256_checker (.*);

`default_nettype wire

// ===== sim/sha256_digest_checker.sv =====
`timescale 1ns / 1ps

module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  msg_byte_i,
  input  logic        has_byte_i,
  input  logic        is_last_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] digest_word_i,
  input  logic [2:0]  word_index_i,
  input  logic        is_last_word_i,
  output int          mismatch_count_o,
  output int          words_due_o
);

  // One digest word as it should leave the block.
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  localparam int unsigned LEN_OFFSET = 56;
  localparam logic [7:0]  END_MARK = 8'h80;

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // Shadow copy of the hashing state.
  logic [31:0]  hash_words [8];
  logic [7:0]   block_bytes [64];
  int unsigned  block_fill;
  logic [60:0]  msg_len_bytes;
  digest_word_t digest_due [$];
  int           fails;

  function automatic logic [31:0] rot_right(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Print one line for a failure and count it.
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    fails++;
  endtask

  // Run the message schedule and 64 rounds over the block window, then fold
  // the working variables into the chaining words.
  task automatic fold_block();
    logic [31:0] sched [64];
    logic [31:0] v [8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int i = 0; i < 16; i++) begin
      sched[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
    end
    for (int i = 16; i < 64; i++) begin
      sched[i] = sched[i-16] + sched[i-7]
               + (rot_right(sched[i-15], 7) ^ rot_right(sched[i-15], 18) ^ (sched[i-15] >> 3))
               + (rot_right(sched[i-2], 17) ^ rot_right(sched[i-2], 19) ^ (sched[i-2] >> 10));
    end
    for (int i = 0; i < 8; i++) begin
      v[i] = hash_words[i];
    end
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rot_right(v[4], 6) ^ rot_right(v[4], 11) ^ rot_right(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + sched[i];
      t2 = (rot_right(v[0], 2) ^ rot_right(v[0], 13) ^ rot_right(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) begin
      hash_words[i] = hash_words[i] + v[i];
    end
  endtask

  // Clear the message state back to its starting point.
  task automatic restart_message();
    for (int i = 0; i < 8; i++) begin
      hash_words[i] = SHA_IV[i];
    end
    block_fill = 0;
    msg_len_bytes = '0;
  endtask

  // Absorb one accepted item; a final item pads, folds and queues the digest.
  task automatic hash_item(input logic [7:0] b, input logic has_b, input logic last);
    logic [63:0]  bit_len;
    digest_word_t dw;
    if (has_b) begin
      block_bytes[block_fill] = b;
      block_fill++;
      msg_len_bytes = msg_len_bytes + 61'd1;
      if (block_fill == 64) begin
        fold_block();
        block_fill = 0;
      end
    end
    if (last) begin
      block_bytes[block_fill] = END_MARK;
      block_fill++;
      // The length does not fit behind the mark: close this block first.
      if (block_fill > LEN_OFFSET) begin
        for (int i = block_fill; i < 64; i++) begin
          block_bytes[i] = 8'h00;
        end
        fold_block();
        block_fill = 0;
      end
      for (int i = block_fill; i < LEN_OFFSET; i++) begin
        block_bytes[i] = 8'h00;
      end
      bit_len = {msg_len_bytes, 3'b000};
      for (int i = 0; i < 8; i++) begin
        block_bytes[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
      end
      fold_block();
      for (int i = 0; i < 8; i++) begin
        dw.word = hash_words[i];
        dw.index = i[2:0];
        dw.last = (i == 7);
        digest_due = {digest_due, dw};
      end
      restart_message();
    end
  endtask

  // Watch both channels; inputs are absorbed before outputs are compared.
  always @(posedge clk_i or negedge rst_ni) begin
    digest_word_t want;
    if (!rst_ni) begin
      restart_message();
      for (int i = 0; i < 64; i++) begin
        block_bytes[i] = 8'h00;
      end
      digest_due.delete();
      fails = 0;
      mismatch_count_o <= 0;
      words_due_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        hash_item(msg_byte_i, has_byte_i, is_last_i);
      end
      if (out_valid_i && out_ready_i) begin
        if (digest_due.size() == 0) begin
          report_mismatch($sformatf("unexpected digest word %h index %0d",
                                    digest_word_i, word_index_i));
        end else begin
          want = digest_due.pop_front();
          if (digest_word_i !== want.word) begin
            report_mismatch($sformatf("digest_word %h, expected %h (index %0d)",
                                      digest_word_i, want.word, want.index));
          end
          if (word_index_i !== want.index) begin
            report_mismatch($sformatf("word_index %0d, expected %0d",
                                      word_index_i, want.index));
          end
          if (is_last_word_i !== want.last) begin
            report_mismatch($sformatf("is_last_word %b, expected %b (index %0d)",
                                      is_last_word_i, want.last, want.index));
          end
        end
      end
      mismatch_count_o <= fails;
      words_due_o <= digest_due.size();
    end
  end

endmodule

// ===== sim/sha256_stream_hasher_unit_test.sv =====
`timescale 1ns / 1ps

module sha256_stream_hasher_unit_test;

  localparam int unsigned ITEM_GOAL = 410;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned MAX_WAIT = 17;
  localparam int unsigned PAD_EDGES [4] = '{55, 56, 63, 64};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  msg_byte_i;
  logic        has_byte_i;
  logic        is_last_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        is_last_word_o;

  int          mismatches;
  int          words_due;
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  bit          in_calm = 1'b0;

  sha256_stream_hasher_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .msg_byte_i     (msg_byte_i),
    .has_byte_i     (has_byte_i),
    .is_last_i      (is_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .is_last_word_o (is_last_word_o)
  );

  sha256_digest_checker u_digest_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .msg_byte_i       (msg_byte_i),
    .has_byte_i       (has_byte_i),
    .is_last_i        (is_last_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .digest_word_i    (digest_word_o),
    .word_index_i     (word_index_o),
    .is_last_word_i   (is_last_word_o),
    .mismatch_count_o (mismatches),
    .words_due_o      (words_due)
  );

  // 8 ns clock.
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned draw_wait(input bit calm);
    return calm ? 0 : $urandom_range(MAX_WAIT, 0);
  endfunction

  // Present one item after a random gap and hold it until it is taken.
  task automatic send_item(input logic [7:0] b, input logic has_b, input logic last);
    int unsigned gap;
    gap = draw_wait(in_calm);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    msg_byte_i <= b;
    has_byte_i <= has_b;
    is_last_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    items_sent++;
  endtask

  // A message of random bytes with stray empty items mixed in. The end mark
  // rides on the last byte, or on an empty item of its own.
  task automatic send_message(input int unsigned len, input bit empty_final);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9, 0) == 0) begin
        send_item(8'($urandom_range(255, 0)), 1'b0, 1'b0);
      end
      send_item(8'($urandom_range(255, 0)), 1'b1, (i == len - 1) && !empty_final);
    end
    if (len == 0 || empty_final) begin
      send_item(8'($urandom_range(255, 0)), 1'b0, 1'b1);
    end
  endtask

  // Receiver: random stalls per digest word, with calm stretches.
  initial begin
    int unsigned stall;
    bit out_calm;
    out_calm = 1'b0;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if ($urandom_range(15, 0) == 0) begin
        out_calm = !out_calm;
      end
      stall = draw_wait(out_calm);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Sender: directed messages, then random ones, then drain and verdict.
  initial begin
    int unsigned len;
    int unsigned msg_no;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    msg_byte_i = 8'h00;
    has_byte_i = 1'b0;
    is_last_i = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // An empty item that is neither byte nor end mark changes nothing.
    send_item(8'hff, 1'b0, 1'b0);
    // The empty message.
    send_item(8'h00, 1'b0, 1'b1);
    // "abc" with the end mark on the last byte.
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    // Extreme byte values, a stray empty item, then an empty final item.
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // A single byte that also ends the message.
    send_item(8'hff, 1'b1, 1'b1);

    // Random messages; the first few sit on the padding boundaries.
    msg_no = 0;
    while (items_sent < ITEM_GOAL) begin
      in_calm = ($urandom_range(3, 0) == 0);
      if (msg_no < 3) begin
        len = PAD_EDGES[msg_no[1:0]];
      end else begin
        case ($urandom_range(19, 0))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: len = $urandom_range(12, 0);
          12, 13, 14, 15, 16: len = PAD_EDGES[2'($urandom_range(3, 0))];
          default: len = $urandom_range(70, 0);
        endcase
      end
      send_message(len, $urandom_range(3, 0) == 0);
      msg_no++;
    end
    in_valid_i <= 1'b0;

    // Wait for the outstanding digests, then watch for stray words.
    while (words_due != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/s256_pkg.sv
src/s256_dpath.sv
src/s256_ctrl.sv
src/sha256_stream_hasher_unit.sv
src/s256_checker.sv
sim/sha256_digest_checker.sv
sim/sha256_stream_hasher_unit_test.sv
